[src/tfli_pkg.sv]
// Shared constants, types and key field helpers for the transfer function LUT interpolator.
`timescale 1ns / 1ps

package tfli_pkg;

   // Register and field geometry
   localparam int KEY_W       = 40;
   localparam int BYTE_W      = 8;
   localparam int CHANNELS    = 4;
   localparam int COUNT_W     = 3;
   localparam int CSR_INDEX_W = 3;

   // Defaults for the top level parameters
   localparam int MAX_KEYS_DEFAULT    = 6;
   localparam int LUT_ENTRIES_DEFAULT = 256;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_ZERO  = 3'd1;

   // Reset values
   localparam logic [COUNT_W-1:0] KEY_COUNT_RESET = 3'd2;
   localparam logic [COUNT_W-1:0] MIN_KEY_COUNT   = 3'd2;
   localparam logic [KEY_W-1:0]   KEY_ONE_RESET   = {KEY_W{1'b1}};

   // Serial arithmetic: multiply takes two color bits a cycle, divide one quotient bit
   localparam int MUL_DIGIT_W = 2;
   localparam int MUL_STEPS   = BYTE_W / MUL_DIGIT_W;
   localparam int DIV_STEPS   = BYTE_W;
   localparam int STEP_W      = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } state_type;

   // Position byte of a control point
   function automatic logic [BYTE_W-1:0] key_pos(input logic [KEY_W-1:0] key);
      return key[KEY_W-1 -: BYTE_W];
   endfunction

   // Color byte of a control point: 0 red, 1 green, 2 blue, 3 alpha
   function automatic logic [BYTE_W-1:0] key_chan(input logic [KEY_W-1:0] key, input int ch);
      return key[KEY_W-1-BYTE_W-BYTE_W*ch -: BYTE_W];
   endfunction

endpackage

[src/tfli_if.sv]
// Valid/ready channel interfaces for LUT index requests and RGBA responses.
`timescale 1ns / 1ps

interface tfli_req_if;
   logic                         valid;
   logic                         ready;
   logic [tfli_pkg::BYTE_W-1:0]  lut_index;

   modport source (output valid, output lut_index, input ready);
   modport sink   (input valid, input lut_index, output ready);
endinterface

interface tfli_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tfli_pkg::BYTE_W-1:0]  red;
   logic [tfli_pkg::BYTE_W-1:0]  green;
   logic [tfli_pkg::BYTE_W-1:0]  blue;
   logic [tfli_pkg::BYTE_W-1:0]  alpha;

   modport source (output valid, output red, output green, output blue, output alpha,
                   input ready);
   modport sink   (input valid, input red, input green, input blue, input alpha,
                   output ready);
endinterface

[src/transfer_function_lut_interpolator_unit.sv]
// Sequence: an accepted request passes through a setup state, a 2-bit serial multiply
//    over the color bytes, a 1-bit restoring divide and a load of the output register.
// Requests are taken only in the idle state, so a new request waits until the last one
//    has left the output state; a stalled response holds the sequencer in that state.
// All four channels share one sequencer and one divisor shift register.
// Reset (synchronous, active high): sequencer idle, no response held, key_count = 2,
//    key_one = all ones, other keys = 0. No clearing pass.
`timescale 1ns / 1ps

module transfer_function_lut_interpolator_unit #(
   parameter int MAX_KEYS    = tfli_pkg::MAX_KEYS_DEFAULT,
   parameter int LUT_ENTRIES = tfli_pkg::LUT_ENTRIES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [tfli_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tfli_pkg::KEY_W-1:0]         csr_wdata,
   tfli_req_if.sink                           req_chan,
   tfli_rsp_if.source                         rsp_chan
);

   import tfli_pkg::*;

   // Scaled positions: index*255 against position*SCALE
   localparam int SCALE = LUT_ENTRIES - 1;
   localparam int PW    = $clog2(255 * SCALE + 1);
   localparam int NW    = PW + 9;   // 2*v + den, v <= 255*den
   localparam int DW    = PW + 8;   // divisor 2*den aligned to the top quotient bit
   localparam logic [BYTE_W-1:0]  IDX_MAX   = BYTE_W'(SCALE);
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_KEYS);
   localparam logic [PW-1:0]      SCALE_PW  = PW'(SCALE);
   localparam logic [PW-1:0]      T_MUL     = PW'(255);

   // Control state
   state_type              state_ff, state_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   accept;
   logic                   load_out;

   // Configuration
   logic [COUNT_W-1:0]     key_count_ff;
   logic [KEY_W-1:0]       keys_ff [MAX_KEYS];

   // Accept-time scan
   logic [BYTE_W-1:0]      idx_clamp;
   logic [PW-1:0]          t_val;
   logic [COUNT_W-1:0]     kcount;
   logic [PW-1:0]          pos_scaled [MAX_KEYS];
   logic [KEY_W-1:0]       ka_sel, kb_sel;
   logic                   scan_stop;

   // Segment registers
   logic [PW-1:0]          t_ff;
   logic [KEY_W-1:0]       ka_ff, kb_ff;

   // Weight setup
   logic [PW-1:0]          pa, pb, num_w, den_w;
   logic [PW-1:0]          num_ff, den_ff, dmn_ff;

   // Serial datapath, one lane per channel
   logic [BYTE_W-1:0]      ca_ff [CHANNELS];
   logic [BYTE_W-1:0]      cb_ff [CHANNELS];
   logic [NW-1:0]          rem_ff [CHANNELS];
   logic [NW-1:0]          mul_next [CHANNELS];
   logic [NW-1:0]          div_next [CHANNELS];
   logic                   div_bit [CHANNELS];
   logic [BYTE_W-1:0]      quo_ff [CHANNELS];
   logic [BYTE_W-1:0]      out_ff [CHANNELS];
   logic [DW-1:0]          dsh_ff;
   logic                   div_bound_ok;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= KEY_COUNT_RESET;
         for (int k = 0; k < MAX_KEYS; k++) begin
            keys_ff[k] <= (k == 1) ? KEY_ONE_RESET : '0;
         end
      end else if (csr_write_en) begin
         if (csr_index == CSR_KEY_COUNT) begin
            key_count_ff <= csr_wdata[COUNT_W-1:0];
         end
         for (int k = 0; k < MAX_KEYS; k++) begin
            if (csr_index == CSR_KEY_ZERO + CSR_INDEX_W'(k)) begin
               keys_ff[k] <= csr_wdata;
            end
         end
      end
   end

   // Clamp index and count, pick the segment
   always_comb begin
      idx_clamp = (req_chan.lut_index > IDX_MAX) ? IDX_MAX : req_chan.lut_index;
      t_val     = PW'(idx_clamp) * T_MUL;
      if (key_count_ff < MIN_KEY_COUNT) begin
         kcount = MIN_KEY_COUNT;
      end else if (key_count_ff > MAX_COUNT) begin
         kcount = MAX_COUNT;
      end else begin
         kcount = key_count_ff;
      end
      for (int k = 0; k < MAX_KEYS; k++) begin
         pos_scaled[k] = PW'(key_pos(keys_ff[k])) * SCALE_PW;
      end
      ka_sel    = keys_ff[0];
      kb_sel    = keys_ff[1];
      scan_stop = 1'b0;
      // advance while a next segment exists and its lower key is below the index
      for (int j = 0; j < MAX_KEYS - 2; j++) begin
         if (!scan_stop) begin
            if ((j + 2 < int'(kcount)) && (pos_scaled[j+1] < t_val)) begin
               ka_sel = keys_ff[j+1];
               kb_sel = keys_ff[j+2];
            end else begin
               scan_stop = 1'b1;
            end
         end
      end
   end

   // Clamped weight num/den
   always_comb begin
      pa = PW'(key_pos(ka_ff)) * SCALE_PW;
      pb = PW'(key_pos(kb_ff)) * SCALE_PW;
      if (pb > pa) begin
         den_w = pb - pa;
         if (t_ff <= pa) begin
            num_w = '0;
         end else if (t_ff >= pb) begin
            num_w = den_w;
         end else begin
            num_w = t_ff - pa;
         end
      end else begin
         num_w = '0;
         den_w = PW'(1);
      end
   end

   // Per-lane multiply step and divide step
   always_comb begin
      div_bound_ok = 1'b1;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         // acc = 4*acc + 2*(a*(den-num) + b*num), plus den on the last digit
         mul_next[ch] = (rem_ff[ch] << MUL_DIGIT_W)
                      + ((NW'(ca_ff[ch][BYTE_W-1 -: MUL_DIGIT_W]) * NW'(dmn_ff)
                        + NW'(cb_ff[ch][BYTE_W-1 -: MUL_DIGIT_W]) * NW'(num_ff)) << 1)
                      + ((step_ff == STEP_W'(MUL_STEPS - 1)) ? NW'(den_ff) : '0);
         div_bit[ch]  = (rem_ff[ch] >= NW'(dsh_ff));
         div_next[ch] = div_bit[ch] ? (rem_ff[ch] - NW'(dsh_ff)) : rem_ff[ch];
         if (rem_ff[ch] >= (NW'(dsh_ff) << 1)) begin
            div_bound_ok = 1'b0;
         end
      end
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      req_chan.ready = 1'b0;
      accept         = 1'b0;
      load_out       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            accept         = req_chan.valid;
            if (req_chan.valid) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            step_in  = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (step_ff == STEP_W'(MUL_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_DIV;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_DIV: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = load_out | (rsp_valid_ff & ~rsp_chan.ready);
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         t_ff  <= t_val;
         ka_ff <= ka_sel;
         kb_ff <= kb_sel;
      end
      case (state_ff)
         ST_PREP: begin
            num_ff <= num_w;
            den_ff <= den_w;
            dmn_ff <= den_w - num_w;
            dsh_ff <= DW'(den_w) << BYTE_W;
            for (int ch = 0; ch < CHANNELS; ch++) begin
               ca_ff[ch]  <= key_chan(ka_ff, ch);
               cb_ff[ch]  <= key_chan(kb_ff, ch);
               rem_ff[ch] <= '0;
            end
         end
         ST_MUL: begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
               rem_ff[ch] <= mul_next[ch];
               ca_ff[ch]  <= ca_ff[ch] << MUL_DIGIT_W;
               cb_ff[ch]  <= cb_ff[ch] << MUL_DIGIT_W;
            end
         end
         ST_DIV: begin
            dsh_ff <= dsh_ff >> 1;
            for (int ch = 0; ch < CHANNELS; ch++) begin
               rem_ff[ch] <= div_next[ch];
               quo_ff[ch] <= {quo_ff[ch][BYTE_W-2:0], div_bit[ch]};
            end
         end
         default: begin
         end
      endcase
      if (load_out) begin
         for (int ch = 0; ch < CHANNELS; ch++) begin
            out_ff[ch] <= quo_ff[ch];
         end
      end
   end

   // Drive the response channel
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.red   = out_ff[0];
   assign rsp_chan.green = out_ff[1];
   assign rsp_chan.blue  = out_ff[2];
   assign rsp_chan.alpha = out_ff[3];

   // An accepted transaction starts the setup cycle
   a_accept_prep: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == ST_PREP))
      else $error("accepted transaction did not start setup");

   // The weight never exceeds one
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (num_ff <= den_ff))
      else $error("interpolation weight above one");

   // Divisor is never zero while the serial units run
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL || state_ff == ST_DIV) |-> (den_ff != '0))
      else $error("zero divisor in serial datapath");

   // Each quotient bit is a single digit: remainder below twice the shifted divisor
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> div_bound_ok)
      else $error("quotient overflow in serial divide");

   // A new response only comes out of the output state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !$past(rsp_chan.valid)) |-> $past(state_ff == ST_OUT))
      else $error("response raised outside the output state");

endmodule

[bench/testbench.sv]
// Self-checking bench for the transfer function LUT interpolator: directed and random lookups.
`timescale 1ns / 1ps

module testbench;
   import tfli_pkg::*;

   localparam int MAX_KEYS       = MAX_KEYS_DEFAULT;
   localparam int LUT_ENTRIES    = LUT_ENTRIES_DEFAULT;
   localparam int TABLE_SCALE    = LUT_ENTRIES - 1;
   localparam int SETTLE_CYCLES  = 20;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_LOOKUPS  = 78;

   // Register index past the last key register
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 3'd7;

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
      logic [BYTE_W-1:0] alpha;
   } rgba_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [KEY_W-1:0]       csr_wdata;

   tfli_req_if req_chan ();
   tfli_rsp_if rsp_chan ();

   transfer_function_lut_interpolator_unit DUT (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan)
   );

   // Shadow copy of the configuration registers
   logic [COUNT_W-1:0] count_shadow;
   logic [KEY_W-1:0]   key_shadow [MAX_KEYS];

   rgba_type rgba_expected [$];
   int    fail_count      = 0;
   int    lookups_checked = 0;
   int    settings_loaded = 0;
   int    idle_cycles     = 0;
   bit    send_quiet      = 1'b0;
   bit    sink_quiet      = 1'b0;
   int    stall_left      = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Pick an idle stretch: mostly none or short, now and then long
   function automatic int pick_gap(input bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [KEY_W-1:0] make_key(input logic [7:0] pos, input logic [31:0] color);
      return {pos, color};
   endfunction

   // Expected RGBA for one index under the shadow configuration
   function automatic rgba_type interpolate_rgba(input logic [BYTE_W-1:0] idx);
      int unsigned       n;
      int unsigned       seg;
      longint unsigned   t255, pa, pb, num, den, ca, cb, v, r;
      logic [KEY_W-1:0]  lo, hi;
      rgba_type          res;
      n = count_shadow;
      if (n < 2) n = 2;
      if (n > MAX_KEYS) n = MAX_KEYS;
      t255 = idx;
      if (t255 > TABLE_SCALE) t255 = TABLE_SCALE;
      t255 = t255 * 255;
      seg = 0;
      // advance while the next segment exists and its lower key lies below the index
      while (seg + 1 < n - 1) begin
         pb = key_shadow[seg + 1][39:32];
         if (pb * TABLE_SCALE >= t255) break;
         seg++;
      end
      lo = key_shadow[seg];
      hi = key_shadow[seg + 1];
      pa = lo[39:32];
      pa = pa * TABLE_SCALE;
      pb = hi[39:32];
      pb = pb * TABLE_SCALE;
      if (pb > pa) begin
         den = pb - pa;
         if (t255 <= pa) num = 0;
         else if (t255 >= pb) num = den;
         else num = t255 - pa;
      end else begin
         num = 0;
         den = 1;
      end
      for (int ch = 0; ch < CHANNELS; ch++) begin
         ca = lo[31 - 8*ch -: 8];
         cb = hi[31 - 8*ch -: 8];
         v = ca * (den - num) + cb * num;
         // round half up
         r = (2 * v + den) / (2 * den);
         if (r > 255) r = 255;
         res[31 - 8*ch -: 8] = r[7:0];
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Predict on each request transaction, check each response transaction, watch for a hang
   always @(posedge clock) begin
      rgba_type want;
      rgba_type got;
      if (!reset) begin
         idle_cycles++;
         if (req_chan.valid && req_chan.ready) begin
            rgba_expected = {rgba_expected, interpolate_rgba(req_chan.lut_index)};
            idle_cycles = 0;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            idle_cycles = 0;
            got = '{rsp_chan.red, rsp_chan.green, rsp_chan.blue, rsp_chan.alpha};
            if (rgba_expected.size() == 0) begin
               $error("response transaction with no request outstanding");
               fail_count++;
            end else begin
               want = rgba_expected.pop_front();
               check_field("red", want.red, got.red);
               check_field("green", want.green, got.green);
               check_field("blue", want.blue, got.blue);
               check_field("alpha", want.alpha, got.alpha);
               lookups_checked++;
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("transfer_function_lut_interpolator_unit verification failed");
            $finish;
         end
      end
   end

   // Response side: hold ready low for random stretches
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_chan.ready <= 1'b1;
         stall_left = pick_gap(sink_quiet);
      end
   end

   // Send one lookup and wait for its transaction
   task automatic send_index(input logic [BYTE_W-1:0] idx);
      int gap;
      gap = pick_gap(send_quiet);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.lut_index <= idx;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
   endtask

   // Drop valid and wait until every response is back and the block is quiet
   task automatic settle_idle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (rgba_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register; write enable stays high until end_writes
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [KEY_W-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      if (idx == CSR_KEY_COUNT) count_shadow = data[COUNT_W-1:0];
      else if (idx != CSR_UNMAPPED) key_shadow[idx - CSR_KEY_ZERO] = data;
   endtask

   task automatic end_writes();
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic load_keys(input logic [COUNT_W-1:0] count,
                            input logic [KEY_W-1:0] keys [MAX_KEYS]);
      settle_idle();
      write_reg(CSR_KEY_COUNT, KEY_W'(count));
      for (int k = 0; k < MAX_KEYS; k++)
         write_reg(CSR_KEY_ZERO + CSR_INDEX_W'(k), keys[k]);
      end_writes();
      settings_loaded++;
   endtask

   task automatic set_count(input logic [COUNT_W-1:0] count);
      settle_idle();
      write_reg(CSR_KEY_COUNT, KEY_W'(count));
      end_writes();
      settings_loaded++;
   endtask

   // Reset configuration: a single ramp from black to white
   task automatic test_reset_keys();
      send_index(8'd0);
      send_index(8'd1);
      send_index(8'd127);
      send_index(8'd128);
      send_index(8'd255);
   endtask

   // Counts below two act as two, above the key limit act as the limit
   task automatic test_count_limits();
      logic [KEY_W-1:0] keys [MAX_KEYS];
      keys[0] = make_key(8'd0,   32'h0000_0000);
      keys[1] = make_key(8'd51,  32'h1020_3040);
      keys[2] = make_key(8'd102, 32'hF0E0_D0C0);
      keys[3] = make_key(8'd153, 32'h0801_80FF);
      keys[4] = make_key(8'd204, 32'h7F80_0155);
      keys[5] = make_key(8'd255, 32'hFFFF_FFFF);
      load_keys(3'd0, keys);
      send_index(8'd200);
      set_count(3'd1);
      send_index(8'd30);
      set_count(3'd7);
      send_index(8'd255);
      send_index(8'd230);
      set_count(3'd6);
      send_index(8'd75);
   endtask

   // A write to an index past the key registers changes nothing
   task automatic test_ignored_register();
      settle_idle();
      write_reg(CSR_UNMAPPED, {KEY_W{1'b1}});
      end_writes();
      send_index(8'd100);
   endtask

   // Flat keys, keys out of order, and indexes outside the segment
   task automatic test_key_ordering();
      logic [KEY_W-1:0] keys [MAX_KEYS];
      foreach (keys[k]) keys[k] = '0;
      keys[0] = make_key(8'd100, 32'h1122_3344);
      keys[1] = make_key(8'd100, 32'hAABB_CCDD);
      load_keys(3'd2, keys);
      send_index(8'd50);
      send_index(8'd100);
      send_index(8'd200);
      keys[0] = make_key(8'd200, 32'h00FF_00FF);
      keys[1] = make_key(8'd50,  32'hFF00_FF00);
      keys[2] = make_key(8'd255, 32'h8080_8080);
      load_keys(3'd3, keys);
      send_index(8'd10);
      send_index(8'd60);
      send_index(8'd220);
      keys[0] = make_key(8'd64,  32'h0000_00FF);
      keys[1] = make_key(8'd192, 32'hFFFF_FF00);
      load_keys(3'd2, keys);
      send_index(8'd0);
      send_index(8'd65);
      send_index(8'd129);
      send_index(8'd255);
   endtask

   // Index near a key in use, at the ends, or anywhere
   function automatic logic [BYTE_W-1:0] pick_index();
      int r;
      int pos;
      r = $urandom_range(0, 99);
      if (r < 15) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      if (r < 40) begin
         pos = key_shadow[$urandom_range(0, MAX_KEYS - 1)][39:32];
         pos = pos + $urandom_range(0, 2) - 1;
         if (pos < 0) pos = 0;
         if (pos > 255) pos = 255;
         return pos[7:0];
      end
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   // Random key sets, counts and lookups, with and without idling
   task automatic test_random_lookups();
      logic [KEY_W-1:0] keys [MAX_KEYS];
      logic [63:0]      word;
      logic [COUNT_W-1:0] count;
      int               spots [$];
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         spots.delete();
         for (int k = 0; k < MAX_KEYS; k++) spots = {spots, int'($urandom_range(0, 255))};
         // most phases use rising positions so every segment gets hit
         if (phase % 4 != 1) spots.sort();
         foreach (keys[k]) begin
            word = {$urandom, $urandom};
            keys[k] = {spots[k][7:0], word[31:0]};
         end
         count = COUNT_W'($urandom_range(0, 7));
         case (phase)
            0: count = 3'd6;
            2: count = 3'd2;
            3: foreach (keys[k]) keys[k] = '0;
            4: foreach (keys[k]) keys[k] = {KEY_W{1'b1}};
            default: ;
         endcase
         load_keys(count, keys);
         send_quiet = (phase % 3 == 2);
         sink_quiet = (phase % 3 == 2);
         for (int i = 0; i < PHASE_LOOKUPS; i++) send_index(pick_index());
         send_quiet = 1'b0;
         sink_quiet = 1'b0;
      end
   endtask

   initial begin
      reset              = 1'b1;
      csr_write_en       = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_chan.valid     = 1'b0;
      req_chan.lut_index = '0;
      count_shadow       = KEY_COUNT_RESET;
      foreach (key_shadow[k]) key_shadow[k] = '0;
      key_shadow[1]      = KEY_ONE_RESET;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      test_reset_keys();
      test_count_limits();
      test_ignored_register();
      test_key_ordering();
      test_random_lookups();
      settle_idle();

      $display("checked %0d lookups over %0d register settings", lookups_checked,
               settings_loaded);
      $display("covered counts 0..7, flat and unordered keys, unmapped register writes");
      if (fail_count == 0) begin
         $display("transfer_function_lut_interpolator_unit verification clean");
      end else begin
         $display("transfer_function_lut_interpolator_unit verification failed");
      end
      $finish;
   end

endmodule
